// ----- rtl/assert_macros.svh -----
// Assertion shorthands used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SRTP_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("srtp assertion failed");

// next-cycle implication
`define SRTP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("srtp assertion failed");

`endif

// ----- rtl/srtp_pkg.sv -----
package srtp_pkg;

   // field widths
   localparam int DELAY_W    = 16;
   localparam int CNT_W      = 25;
   localparam int REST_W     = 28;
   localparam int POS_W      = 32;
   localparam int PHASE_W    = 2;
   localparam int DECEL_W    = 24;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 25;

   // divider widths: num = 2*delay + rest, den = 4*count + 1
   localparam int NUM_W      = 29;
   localparam int DEN_W      = 27;
   localparam int MAG_W      = 28;
   localparam int REM_W      = 28;
   localparam int DIV_CNT_W  = 5;

   // motion phases
   localparam logic [PHASE_W-1:0] PH_STOP  = 2'd0;
   localparam logic [PHASE_W-1:0] PH_ACCEL = 2'd1;
   localparam logic [PHASE_W-1:0] PH_RUN   = 2'd2;
   localparam logic [PHASE_W-1:0] PH_DECEL = 2'd3;

   // item operations
   localparam logic OP_START = 1'b0;
   localparam logic OP_EVENT = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_DELAY  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CRUISE_DELAY = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RAMP_DOWN    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DECEL_COUNT  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_START_PHASE  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_START_COUNT  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_DIRECTION    = 3'd6;

   localparam logic [DELAY_W-1:0] FIRST_DELAY_RST = 16'd1000;

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_EXEC   = 4'b0010,
      S_DIV    = 4'b0100,
      S_COMMIT = 4'b1000
   } ctrl_state_type;

   typedef enum logic [2:0] {
      D_IDLE = 3'b001,
      D_RUN  = 3'b010,
      D_FIX  = 3'b100
   } div_state_type;

   typedef struct packed {
      logic latch;
      logic div_start;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic need_div;
      logic div_done;
   } stat_type;

endpackage

// ----- rtl/srtp_if.sv -----
interface srtp_req_if;
   logic        valid;
   logic        ready;
   logic        operation;
   logic [15:0] counter;

   modport source (output valid, output operation, output counter, input ready);
   modport sink   (input valid, input operation, input counter, output ready);
endinterface

interface srtp_rsp_if;
   logic               valid;
   logic               ready;
   logic [15:0]        compare_value;
   logic               step_done;
   logic [1:0]         phase;
   logic               moving;
   logic               ignored;
   logic signed [31:0] position;
   logic [31:0]        pulse_total;

   modport source (output valid, output compare_value, output step_done, output phase,
                   output moving, output ignored, output position, output pulse_total,
                   input ready);
   modport sink   (input valid, input compare_value, input step_done, input phase,
                   input moving, input ignored, input position, input pulse_total,
                   output ready);
endinterface

// ----- rtl/srtp_div.sv -----
// Signed restoring divider, one quotient bit per cycle, truncates toward zero.
module srtp_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [srtp_pkg::NUM_W-1:0]   num_i,
   input  logic [srtp_pkg::DEN_W-1:0]   den_i,
   output logic                         done_o,
   output logic [srtp_pkg::NUM_W-1:0]   quo_o,
   output logic [srtp_pkg::REM_W-1:0]   rem_o
);

   localparam int NUM_W = srtp_pkg::NUM_W;
   localparam int DEN_W = srtp_pkg::DEN_W;
   localparam int MAG_W = srtp_pkg::MAG_W;
   localparam int REM_W = srtp_pkg::REM_W;
   localparam int CW    = srtp_pkg::DIV_CNT_W;

   srtp_pkg::div_state_type state_ff, state_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [DEN_W-1:0] dmag_ff, dmag_in;
   logic [MAG_W-1:0] quo_ff, quo_in;
   logic [REM_W-1:0] rem_ff, rem_in;
   logic             negq_ff, negq_in;
   logic             negr_ff, negr_in;
   logic             done_ff, done_in;
   logic [NUM_W-1:0] qout_ff, qout_in;
   logic [REM_W-1:0] rout_ff, rout_in;

   logic [NUM_W-1:0] num_abs;
   logic [DEN_W-1:0] den_abs;
   logic [REM_W-1:0] rem_sh;
   logic [REM_W:0]   diff;

   assign num_abs = num_i[NUM_W-1] ? (~num_i + 1'b1) : num_i;
   assign den_abs = den_i[DEN_W-1] ? (~den_i + 1'b1) : den_i;
   assign rem_sh  = {rem_ff[REM_W-2:0], quo_ff[MAG_W-1]};
   assign diff    = {1'b0, rem_sh} - (REM_W+1)'(dmag_ff);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      dmag_in  = dmag_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      negq_in  = negq_ff;
      negr_in  = negr_ff;
      done_in  = 1'b0;
      qout_in  = qout_ff;
      rout_in  = rout_ff;
      case (state_ff)
         srtp_pkg::D_IDLE: begin
            if (start) begin
               dmag_in  = den_abs;
               quo_in   = num_abs[MAG_W-1:0];
               rem_in   = '0;
               cnt_in   = '0;
               negq_in  = num_i[NUM_W-1] ^ den_i[DEN_W-1];
               negr_in  = num_i[NUM_W-1];
               state_in = srtp_pkg::D_RUN;
            end
         end
         srtp_pkg::D_RUN: begin
            if (!diff[REM_W]) begin
               rem_in = diff[REM_W-1:0];
               quo_in = {quo_ff[MAG_W-2:0], 1'b1};
            end else begin
               rem_in = rem_sh;
               quo_in = {quo_ff[MAG_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(MAG_W - 1)) begin
               state_in = srtp_pkg::D_FIX;
            end
         end
         srtp_pkg::D_FIX: begin
            qout_in  = negq_ff ? (~{1'b0, quo_ff} + 1'b1) : {1'b0, quo_ff};
            rout_in  = negr_ff ? (~rem_ff + 1'b1) : rem_ff;
            done_in  = 1'b1;
            state_in = srtp_pkg::D_IDLE;
         end
         default: begin
            state_in = srtp_pkg::D_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= srtp_pkg::D_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      cnt_ff  <= cnt_in;
      dmag_ff <= dmag_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      negq_ff <= negq_in;
      negr_ff <= negr_in;
      qout_ff <= qout_in;
      rout_ff <= rout_in;
   end

   assign done_o = done_ff;
   assign quo_o  = qout_ff;
   assign rem_o  = rout_ff;

endmodule

// ----- rtl/srtp_dp.sv -----
// Datapath: registers, ramp state, next-state logic, divider and result register.
module srtp_dp #(
   parameter int STEP_BITS = 24
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [srtp_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [srtp_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  logic                                  req_operation,
   input  logic [srtp_pkg::DELAY_W-1:0]          req_counter,
   input  srtp_pkg::cmd_type                     cmd,
   output srtp_pkg::stat_type                    stat,
   output logic [srtp_pkg::DELAY_W-1:0]          rsp_compare_value,
   output logic                                  rsp_step_done,
   output logic [srtp_pkg::PHASE_W-1:0]          rsp_phase,
   output logic                                  rsp_moving,
   output logic                                  rsp_ignored,
   output logic signed [srtp_pkg::POS_W-1:0]     rsp_position,
   output logic [srtp_pkg::POS_W-1:0]            rsp_pulse_total
);

   localparam int DELAY_W = srtp_pkg::DELAY_W;
   localparam int CNT_W   = srtp_pkg::CNT_W;
   localparam int REST_W  = srtp_pkg::REST_W;
   localparam int POS_W   = srtp_pkg::POS_W;
   localparam int PHASE_W = srtp_pkg::PHASE_W;
   localparam int DECEL_W = srtp_pkg::DECEL_W;
   localparam int NUM_W   = srtp_pkg::NUM_W;
   localparam int DEN_W   = srtp_pkg::DEN_W;
   localparam int REM_W   = srtp_pkg::REM_W;
   localparam int CMP_W   = (STEP_BITS > DECEL_W) ? STEP_BITS : DECEL_W;
   localparam logic [CMP_W-1:0] STEP_MASK = {CMP_W{1'b1}} >> (CMP_W - STEP_BITS);

   // configuration
   logic [DELAY_W-1:0] first_delay_ff, first_delay_in;
   logic [DELAY_W-1:0] cruise_delay_ff, cruise_delay_in;
   logic [DECEL_W-1:0] ramp_down_ff, ramp_down_in;
   logic [CNT_W-1:0]   decel_count_ff, decel_count_in;
   logic [PHASE_W-1:0] start_phase_ff, start_phase_in;
   logic               start_count_ff, start_count_in;
   logic               direction_ff, direction_in;

   // latched item
   logic               op_ff;
   logic [DELAY_W-1:0] counter_ff;

   // ramp state
   logic [PHASE_W-1:0]   phase_ff, phase_in;
   logic                 moving_ff, moving_in;
   logic                 half_ff, half_in;
   logic [DELAY_W-1:0]   delay_ff, delay_in;
   logic [CNT_W-1:0]     ramp_ff, ramp_in;
   logic [STEP_BITS-1:0] steps_ff, steps_in;
   logic [REST_W-1:0]    rest_ff, rest_in;
   logic [DELAY_W-1:0]   last_ff, last_in;
   logic [POS_W-1:0]     pos_ff, pos_in;
   logic [POS_W-1:0]     total_ff, total_in;

   // result register
   logic [DELAY_W-1:0] cmp_ff, cmp_in;
   logic               done_ff, done_in;
   logic               ign_ff, ign_in;
   logic [PHASE_W-1:0] ph_out_ff;
   logic               mov_out_ff;
   logic [POS_W-1:0]   pos_out_ff;
   logic [POS_W-1:0]   tot_out_ff;

   // divider
   logic [CNT_W-1:0]   cnt_inc;
   logic [NUM_W-1:0]   div_num;
   logic [DEN_W-1:0]   div_den;
   logic               div_done;
   logic [NUM_W-1:0]   div_quo;
   logic [REM_W-1:0]   div_rem;
   logic [DELAY_W-1:0] ramp_delay;

   logic [STEP_BITS-1:0] steps_inc;
   logic                 at_decel;
   logic [DELAY_W-1:0]   nd;

   assign cnt_inc = ramp_ff + 1'b1;
   // 4*count+1 is the count shifted up with a one below
   assign div_den = {cnt_inc, 2'b01};
   assign div_num = {{(NUM_W-DELAY_W-1){1'b0}}, delay_ff, 1'b0}
                  + {{(NUM_W-REST_W){rest_ff[REST_W-1]}}, rest_ff};

   srtp_div u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.div_start),
      .num_i  (div_num),
      .den_i  (div_den),
      .done_o (div_done),
      .quo_o  (div_quo),
      .rem_o  (div_rem)
   );

   assign ramp_delay = delay_ff - div_quo[DELAY_W-1:0];
   assign steps_inc  = steps_ff + 1'b1;
   assign at_decel   = CMP_W'(steps_inc) >= (CMP_W'(ramp_down_ff) & STEP_MASK);

   assign stat.need_div = (op_ff == srtp_pkg::OP_EVENT) && moving_ff && half_ff
                        && ((phase_ff == srtp_pkg::PH_ACCEL)
                            || (phase_ff == srtp_pkg::PH_DECEL));
   assign stat.div_done = div_done;

   // configuration writes
   always_comb begin
      first_delay_in  = first_delay_ff;
      cruise_delay_in = cruise_delay_ff;
      ramp_down_in    = ramp_down_ff;
      decel_count_in  = decel_count_ff;
      start_phase_in  = start_phase_ff;
      start_count_in  = start_count_ff;
      direction_in    = direction_ff;
      if (csr_we) begin
         case (csr_index)
            srtp_pkg::CSR_FIRST_DELAY:  first_delay_in  = csr_wdata[DELAY_W-1:0];
            srtp_pkg::CSR_CRUISE_DELAY: cruise_delay_in = csr_wdata[DELAY_W-1:0];
            srtp_pkg::CSR_RAMP_DOWN:    ramp_down_in    = csr_wdata[DECEL_W-1:0];
            srtp_pkg::CSR_DECEL_COUNT:  decel_count_in  = csr_wdata[CNT_W-1:0];
            srtp_pkg::CSR_START_PHASE:  start_phase_in  = csr_wdata[PHASE_W-1:0];
            srtp_pkg::CSR_START_COUNT:  start_count_in  = csr_wdata[0];
            srtp_pkg::CSR_DIRECTION:    direction_in    = csr_wdata[0];
            default: ;
         endcase
      end
   end

   // next state of one item
   always_comb begin
      phase_in = phase_ff;
      moving_in = moving_ff;
      half_in  = half_ff;
      delay_in = delay_ff;
      ramp_in  = ramp_ff;
      steps_in = steps_ff;
      rest_in  = rest_ff;
      last_in  = last_ff;
      pos_in   = pos_ff;
      total_in = total_ff;
      cmp_in   = '0;
      done_in  = 1'b0;
      ign_in   = 1'b0;
      nd       = '0;
      if (op_ff == srtp_pkg::OP_START) begin
         if (moving_ff) begin
            ign_in = 1'b1;
         end else begin
            delay_in  = first_delay_ff;
            phase_in  = start_phase_ff;
            ramp_in   = {CNT_W{start_count_ff}};
            moving_in = 1'b1;
            cmp_in    = counter_ff + (first_delay_ff >> 1);
         end
      end else if (!moving_ff) begin
         ign_in = 1'b1;
      end else begin
         cmp_in  = counter_ff + (delay_ff >> 1);
         half_in = ~half_ff;
         if (half_ff) begin
            case (phase_ff)
               srtp_pkg::PH_ACCEL: begin
                  done_in = 1'b1;
                  ramp_in = cnt_inc;
                  nd      = ramp_delay;
                  rest_in = div_rem;
                  if (at_decel) begin
                     ramp_in  = decel_count_ff;
                     phase_in = srtp_pkg::PH_DECEL;
                  end else if (ramp_delay <= cruise_delay_ff) begin
                     last_in  = ramp_delay;
                     nd       = cruise_delay_ff;
                     rest_in  = '0;
                     phase_in = srtp_pkg::PH_RUN;
                  end
               end
               srtp_pkg::PH_RUN: begin
                  done_in = 1'b1;
                  nd      = cruise_delay_ff;
                  if (at_decel) begin
                     ramp_in  = decel_count_ff;
                     nd       = last_ff;
                     phase_in = srtp_pkg::PH_DECEL;
                  end
               end
               srtp_pkg::PH_DECEL: begin
                  done_in = 1'b1;
                  ramp_in = cnt_inc;
                  nd      = ramp_delay;
                  rest_in = div_rem;
                  if (!cnt_inc[CNT_W-1]) begin
                     phase_in = srtp_pkg::PH_STOP;
                  end
               end
               default: begin
                  // stop phase: move ends
                  steps_in  = '0;
                  rest_in   = '0;
                  moving_in = 1'b0;
               end
            endcase
            if (done_in) begin
               steps_in = steps_inc;
               total_in = total_ff + 1'b1;
               pos_in   = direction_ff ? (pos_ff - 1'b1) : (pos_ff + 1'b1);
            end
            delay_in = nd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_delay_ff  <= srtp_pkg::FIRST_DELAY_RST;
         cruise_delay_ff <= '0;
         ramp_down_ff    <= '0;
         decel_count_ff  <= '1;
         start_phase_ff  <= srtp_pkg::PH_STOP;
         start_count_ff  <= 1'b0;
         direction_ff    <= 1'b0;
         phase_ff  <= srtp_pkg::PH_STOP;
         moving_ff <= 1'b0;
         half_ff   <= 1'b0;
         delay_ff  <= '0;
         ramp_ff   <= '0;
         steps_ff  <= '0;
         rest_ff   <= '0;
         last_ff   <= '0;
         pos_ff    <= '0;
         total_ff  <= '0;
      end else begin
         first_delay_ff  <= first_delay_in;
         cruise_delay_ff <= cruise_delay_in;
         ramp_down_ff    <= ramp_down_in;
         decel_count_ff  <= decel_count_in;
         start_phase_ff  <= start_phase_in;
         start_count_ff  <= start_count_in;
         direction_ff    <= direction_in;
         if (cmd.commit) begin
            phase_ff  <= phase_in;
            moving_ff <= moving_in;
            half_ff   <= half_in;
            delay_ff  <= delay_in;
            ramp_ff   <= ramp_in;
            steps_ff  <= steps_in;
            rest_ff   <= rest_in;
            last_ff   <= last_in;
            pos_ff    <= pos_in;
            total_ff  <= total_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         op_ff      <= req_operation;
         counter_ff <= req_counter;
      end
      if (cmd.commit) begin
         cmp_ff     <= cmp_in;
         done_ff    <= done_in;
         ign_ff     <= ign_in;
         ph_out_ff  <= phase_in;
         mov_out_ff <= moving_in;
         pos_out_ff <= pos_in;
         tot_out_ff <= total_in;
      end
   end

   assign rsp_compare_value = cmp_ff;
   assign rsp_step_done     = done_ff;
   assign rsp_phase         = ph_out_ff;
   assign rsp_moving        = mov_out_ff;
   assign rsp_ignored       = ign_ff;
   assign rsp_position      = pos_out_ff;
   assign rsp_pulse_total   = tot_out_ff;

endmodule

// ----- rtl/srtp_ctrl.sv -----
// Controller: sequences accept, optional divide and commit of one item.
module srtp_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  srtp_pkg::stat_type stat,
   output srtp_pkg::cmd_type  cmd
);

   srtp_pkg::ctrl_state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == srtp_pkg::S_IDLE);

   always_comb begin
      state_in      = state_ff;
      cmd.latch     = 1'b0;
      cmd.div_start = 1'b0;
      cmd.commit    = 1'b0;
      case (state_ff)
         srtp_pkg::S_IDLE: begin
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = srtp_pkg::S_EXEC;
            end
         end
         srtp_pkg::S_EXEC: begin
            if (stat.need_div) begin
               cmd.div_start = 1'b1;
               state_in      = srtp_pkg::S_DIV;
            end else begin
               state_in = srtp_pkg::S_COMMIT;
            end
         end
         srtp_pkg::S_DIV: begin
            if (stat.div_done) begin
               state_in = srtp_pkg::S_COMMIT;
            end
         end
         srtp_pkg::S_COMMIT: begin
            if (out_free) begin
               cmd.commit = 1'b1;
               state_in   = srtp_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = srtp_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= srtp_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- rtl/stepper_trapezoid_ramp_pulser_top.sv -----
// Trapezoidal stepper ramp pulser, one item per timer toggle.
//
// req_ch: operation (0 start a move, 1 compare event) and the timer counter.
// rsp_ch: exactly one result per item: next compare value, step_done, phase,
//   moving, ignored, position and pulse_total.
// csr_*: write-only register port (index 0..6), to be written only while idle;
//   the block itself does not enforce this.
// Flow: a start, an ignored item, a run or stop step, or the first toggle
//   of a step passes the IDLE, EXEC and COMMIT states. A step in accel or
//   decel runs the ramp division through the bit-serial divider: 28 quotient
//   bits plus a sign fix-up, in the DIV state between EXEC and COMMIT.
// Throughput: one item at a time; the next item is accepted in the cycle after
//   the previous result is loaded.
// The result sits in an output register, so a new item is accepted while the
//   last result still waits; a stalled receiver only holds the block before it
//   loads the following result.
// Reset (synchronous, active high): no move, phase stop, counters, position and
//   pulse total cleared, registers at their defaults (first delay 1000, decel
//   count -1, all others zero).
module stepper_trapezoid_ramp_pulser_top #(
   parameter int STEP_BITS = 24   // width of the step counter used for decel start
) (
   input  logic                                  clock,
   input  logic                                  reset,
   srtp_req_if.sink                              req_ch,
   srtp_rsp_if.source                            rsp_ch,
   input  logic                                  csr_we,
   input  logic [srtp_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [srtp_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   srtp_pkg::cmd_type  cmd;
   srtp_pkg::stat_type stat;

   // sequencing: accept, divide when the step ramps, commit into the result register
   srtp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // ramp state, registers, divider and result payload
   srtp_dp #(
      .STEP_BITS (STEP_BITS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_operation     (req_ch.operation),
      .req_counter       (req_ch.counter),
      .cmd               (cmd),
      .stat              (stat),
      .rsp_compare_value (rsp_ch.compare_value),
      .rsp_step_done     (rsp_ch.step_done),
      .rsp_phase         (rsp_ch.phase),
      .rsp_moving        (rsp_ch.moving),
      .rsp_ignored       (rsp_ch.ignored),
      .rsp_position      (rsp_ch.position),
      .rsp_pulse_total   (rsp_ch.pulse_total)
   );

endmodule

// ----- rtl/srtp_checker.sv -----
`include "assert_macros.svh"

// Port-level checks of the ramp pulser.
module srtp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_compare_value,
   input logic        rsp_step_done,
   input logic [1:0]  rsp_phase,
   input logic        rsp_moving,
   input logic        rsp_ignored,
   input logic [31:0] rsp_position,
   input logic [31:0] rsp_pulse_total
);

   // stalled result holds
   `SRTP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_compare_value) && $stable(rsp_step_done) && $stable(rsp_phase) && $stable(rsp_moving) && $stable(rsp_ignored) && $stable(rsp_position) && $stable(rsp_pulse_total))

   // one item in flight: no accept right after an accept
   `SRTP_ASSERT_NEXT(a_one_item, clock, reset, req_valid && req_ready, !req_ready)

   // ignored items program nothing and take no step
   `SRTP_ASSERT_SAME(a_ignored, clock, reset, rsp_valid && rsp_ignored, !rsp_step_done && (rsp_compare_value == 16'd0))

   // an idle engine is always in the stop phase
   `SRTP_ASSERT_SAME(a_idle_stop, clock, reset, rsp_valid && !rsp_moving, rsp_phase == srtp_pkg::PH_STOP)

   // a completed step belongs to an active move
   `SRTP_ASSERT_SAME(a_step_moving, clock, reset, rsp_valid && rsp_step_done, rsp_moving && !rsp_ignored)

endmodule

bind stepper_trapezoid_ramp_pulser_top srtp_checker u_srtp_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_ch.valid),
   .req_ready         (req_ch.ready),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .rsp_compare_value (rsp_ch.compare_value),
   .rsp_step_done     (rsp_ch.step_done),
   .rsp_phase         (rsp_ch.phase),
   .rsp_moving        (rsp_ch.moving),
   .rsp_ignored       (rsp_ch.ignored),
   .rsp_position      (rsp_ch.position),
   .rsp_pulse_total   (rsp_ch.pulse_total)
);
